// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker file crl_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define CRL_ASSERT_DIS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define CRL_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/crl_pkg.sv =====
package crl_pkg;

    localparam int RING_DEPTH_DEF = 256;
    localparam int STAMP_BITS_DEF = 32;
    localparam int QUEUE_DEPTH    = 2;

    localparam int TIME_BITS     = 32;
    localparam int CLICK_BITS    = 8;
    localparam int LIMIT_BITS    = 8;
    localparam int COOL_BITS     = 16;
    localparam int WINDOW_BITS   = 16;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CLICK_BITS-1:0] CLICK_MAX = 8'hFF;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_BITS-1:0] CFG_LEFT_LIMIT     = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_LEFT_COOLDOWN  = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_RIGHT_LIMIT    = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_RIGHT_COOLDOWN = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_WINDOW         = 3'd4;

    // Register values after reset.
    localparam logic [LIMIT_BITS-1:0]  LEFT_LIMIT_RST     = 8'd16;
    localparam logic [COOL_BITS-1:0]   LEFT_COOLDOWN_RST  = 16'd50;
    localparam logic [LIMIT_BITS-1:0]  RIGHT_LIMIT_RST    = 8'd18;
    localparam logic [COOL_BITS-1:0]   RIGHT_COOLDOWN_RST = 16'd0;
    localparam logic [WINDOW_BITS-1:0] WINDOW_RST         = 16'd1000;

    localparam logic [1:0] REQ_LEFT    = 2'd0;
    localparam logic [1:0] REQ_RIGHT   = 2'd1;
    localparam logic [1:0] KEY_RELEASE = 2'd0;
    localparam logic [1:0] KEY_PRESS   = 2'd1;

    localparam logic SEL_LEFT  = 1'b0;
    localparam logic SEL_RIGHT = 1'b1;

    localparam logic [1:0] VERDICT_PASS     = 2'd0;
    localparam logic [1:0] VERDICT_COOLDOWN = 2'd1;
    localparam logic [1:0] VERDICT_RATE     = 2'd2;
    localparam logic [1:0] VERDICT_RELEASE  = 2'd3;

    typedef enum logic [1:0] {
        KIND_OTHER   = 2'd0,
        KIND_PRESS   = 2'd1,
        KIND_RELEASE = 2'd2,
        KIND_HOLD    = 2'd3
    } crl_kind_t;

    typedef struct packed {
        crl_kind_t             kind;
        logic                  btn;
        logic [TIME_BITS-1:0]  time_ms;
    } crl_item_t;

    typedef struct packed {
        logic                  forward;
        logic [1:0]            verdict;
        logic [CLICK_BITS-1:0] clicks;
    } crl_result_t;

    typedef struct packed {
        logic [1:0][LIMIT_BITS-1:0] limit;
        logic [1:0][COOL_BITS-1:0]  cooldown;
        logic [WINDOW_BITS-1:0]     window;
    } crl_cfg_t;

endpackage

// ===== rtl/core/crl_front.sv =====
module crl_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [1:0]                    req_type,
    input  logic [1:0]                    key_value,
    input  logic [crl_pkg::TIME_BITS-1:0] time_ms,
    output crl_pkg::crl_item_t            item,
    output logic                          item_valid,
    input  logic                          item_ready
);
    import crl_pkg::*;

    crl_item_t item_reg, item_next;
    logic      valid_reg, valid_next;
    logic      take;

    assign s_tready = !valid_reg || item_ready;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        item_next         = item_reg;
        item_next.btn     = req_type[0];
        item_next.time_ms = time_ms;
        if (req_type == REQ_LEFT || req_type == REQ_RIGHT) begin
            case (key_value)
                KEY_PRESS:   item_next.kind = KIND_PRESS;
                KEY_RELEASE: item_next.kind = KIND_RELEASE;
                default:     item_next.kind = KIND_HOLD;
            endcase
        end else begin
            item_next.kind = KIND_OTHER;
        end
        valid_next = take || (valid_reg && !item_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg <= item_next;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

// ===== rtl/core/crl_queue.sv =====
module crl_queue #(
    parameter int DEPTH = crl_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  crl_pkg::crl_item_t in_item,
    input  logic               in_valid,
    output logic               in_ready,
    output crl_pkg::crl_item_t out_item,
    output logic               out_valid,
    input  logic               out_ready
);
    import crl_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

    crl_item_t           slot_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] fill_reg, fill_next;
    logic                push, pop;

    assign in_ready  = fill_reg != FULL_CNT;
    assign out_valid = fill_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== rtl/core/crl_back.sv =====
module crl_back #(
    parameter int RING_DEPTH = crl_pkg::RING_DEPTH_DEF,
    parameter int STAMP_BITS = crl_pkg::STAMP_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  crl_pkg::crl_item_t   item,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  crl_pkg::crl_cfg_t    cfg,
    output crl_pkg::crl_result_t result,
    output logic                 result_valid,
    input  logic                 result_ready
);
    import crl_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int LW = (AW > LIMIT_BITS) ? AW : LIMIT_BITS;
    localparam logic [AW-1:0] RING_CAP  = AW'(RING_DEPTH - 1);
    localparam logic [AW:0]   RING_SIZE = (AW + 1)'(RING_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DECIDE = 4'b0010,
        ST_EXPIRE = 4'b0100,
        ST_LIMIT  = 4'b1000
    } crl_state_t;

    typedef struct packed {
        logic [AW-1:0]         head;
        logic [AW-1:0]         count;
        logic [STAMP_BITS-1:0] last;
        logic                  seen;
        logic                  dropped;
    } btn_state_t;

    crl_state_t            state_reg, state_next;
    crl_item_t             work_reg, work_next;
    btn_state_t            btn_reg [2];
    btn_state_t            cur, cur_next;
    logic                  btn_we;
    logic [STAMP_BITS-1:0] stamp_mem [2][RING_DEPTH];
    logic [STAMP_BITS-1:0] rdata_reg;
    logic                  mem_we, mem_re;
    logic [AW-1:0]         rd_idx, wr_idx, head_inc;
    logic [AW:0]           wr_sum;
    crl_result_t           out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_free;
    logic [STAMP_BITS-1:0] now, since_last, age;
    logic                  cool_ok, expired, rate_full;
    logic [LW-1:0]         lim_wide, cnt_wide;
    logic                  emit;
    logic [1:0]            report_verdict;
    logic [AW-1:0]         report_cnt;

    assign cur        = btn_reg[work_reg.btn];
    assign now        = STAMP_BITS'(work_reg.time_ms);
    assign since_last = now - cur.last;
    assign cool_ok    = !cur.seen ||
                        since_last >= STAMP_BITS'(cfg.cooldown[work_reg.btn]);
    // In ST_EXPIRE the read data belongs to the stamp at the current head.
    assign age        = now - rdata_reg;
    assign expired    = age >= STAMP_BITS'(cfg.window);
    assign lim_wide   = (LW'(cfg.limit[work_reg.btn]) > LW'(RING_CAP)) ?
                        LW'(RING_CAP) : LW'(cfg.limit[work_reg.btn]);
    assign rate_full  = LW'(cur.count) >= lim_wide;
    assign head_inc   = (cur.head == RING_CAP) ? '0 : cur.head + 1'b1;
    assign wr_sum     = {1'b0, cur.head} + {1'b0, cur.count};
    assign wr_idx     = (wr_sum >= RING_SIZE) ? AW'(wr_sum - RING_SIZE) : AW'(wr_sum);
    assign out_free   = !out_valid_reg || result_ready;
    assign item_ready = state_reg == ST_IDLE;

    always_comb begin
        state_next     = state_reg;
        work_next      = work_reg;
        cur_next       = cur;
        btn_we         = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        rd_idx         = cur.head;
        emit           = 1'b0;
        report_verdict = VERDICT_PASS;
        report_cnt     = cur.count;
        case (state_reg)
            ST_IDLE: begin
                if (item_valid) begin
                    work_next  = item;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (out_free) begin
                    case (work_reg.kind)
                        KIND_PRESS: begin
                            if (!cool_ok) begin
                                cur_next.dropped = 1'b1;
                                btn_we           = 1'b1;
                                emit             = 1'b1;
                                report_verdict   = VERDICT_COOLDOWN;
                                state_next       = ST_IDLE;
                            end else if (cur.count == '0) begin
                                state_next = ST_LIMIT;
                            end else begin
                                mem_re     = 1'b1;
                                state_next = ST_EXPIRE;
                            end
                        end
                        KIND_RELEASE: begin
                            emit           = 1'b1;
                            report_verdict = cur.dropped ? VERDICT_RELEASE : VERDICT_PASS;
                            state_next     = ST_IDLE;
                        end
                        KIND_HOLD: begin
                            emit       = 1'b1;
                            state_next = ST_IDLE;
                        end
                        default: begin
                            emit       = 1'b1;
                            report_cnt = '0;
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_EXPIRE: begin
                // One stamp retires per cycle; the next head is read meanwhile.
                if (expired) begin
                    cur_next.head  = head_inc;
                    cur_next.count = cur.count - 1'b1;
                    btn_we         = 1'b1;
                    if (cur.count == AW'(1)) begin
                        state_next = ST_LIMIT;
                    end else begin
                        mem_re = 1'b1;
                        rd_idx = head_inc;
                    end
                end else begin
                    state_next = ST_LIMIT;
                end
            end
            ST_LIMIT: begin
                if (out_free) begin
                    emit       = 1'b1;
                    btn_we     = 1'b1;
                    state_next = ST_IDLE;
                    if (rate_full) begin
                        cur_next.dropped = 1'b1;
                        report_verdict   = VERDICT_RATE;
                    end else begin
                        mem_we           = 1'b1;
                        cur_next.count   = cur.count + 1'b1;
                        cur_next.last    = now;
                        cur_next.seen    = 1'b1;
                        cur_next.dropped = 1'b0;
                        report_cnt       = cur.count + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign cnt_wide = LW'(report_cnt);

    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result_ready;
        if (emit) begin
            out_next.forward = report_verdict == VERDICT_PASS;
            out_next.verdict = report_verdict;
            out_next.clicks  = (cnt_wide > LW'(CLICK_MAX)) ?
                               CLICK_MAX : cnt_wide[CLICK_BITS-1:0];
            out_valid_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            btn_reg[SEL_LEFT]  <= '0;
            btn_reg[SEL_RIGHT] <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (btn_we) begin
                btn_reg[work_reg.btn] <= cur_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stamp_mem[work_reg.btn][wr_idx] <= now;
        end
        if (mem_re) begin
            rdata_reg <= stamp_mem[work_reg.btn][rd_idx];
        end
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

endmodule

// ===== rtl/core/click_rate_limiter.sv =====
// Channel   Direction  tdata             tuser
// s_        in         time_ms [31:0]    req_type [1:0], key_value [3:2]
// m_        out        clicks  [7:0]     forward [0], verdict [2:1]
//
// An event that is not a press, or a press dropped by the cooldown, passes the front register
// and the queue to ST_DECIDE, which registers its result. Other presses go to ST_LIMIT,
// via ST_EXPIRE if stamps are held, which retires old stamps through the one read port.
// Reset is synchronous; the stamp memories are not cleared and need no pass.
// A two-entry queue lets input transfers continue while a result waits on m_tready.
module click_rate_limiter #(
    parameter int RING_DEPTH = crl_pkg::RING_DEPTH_DEF,
    parameter int STAMP_BITS = crl_pkg::STAMP_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,  // time_ms
    input  logic [3:0]                        s_tuser,  // req_type, key_value
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,  // clicks_in_window
    output logic [2:0]                        m_tuser,  // forward, verdict
    input  logic                              cfg_wr_en,
    input  logic [crl_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [crl_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
    import crl_pkg::*;

    crl_cfg_t    cfg_reg, cfg_next;
    crl_item_t   fr_item, q_item;
    logic        fr_valid, fr_ready, q_valid, q_ready;
    crl_result_t res;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_LEFT_LIMIT:     cfg_next.limit[SEL_LEFT]     = cfg_wdata[LIMIT_BITS-1:0];
                CFG_LEFT_COOLDOWN:  cfg_next.cooldown[SEL_LEFT]  = cfg_wdata[COOL_BITS-1:0];
                CFG_RIGHT_LIMIT:    cfg_next.limit[SEL_RIGHT]    = cfg_wdata[LIMIT_BITS-1:0];
                CFG_RIGHT_COOLDOWN: cfg_next.cooldown[SEL_RIGHT] = cfg_wdata[COOL_BITS-1:0];
                CFG_WINDOW:         cfg_next.window              = cfg_wdata[WINDOW_BITS-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.limit[SEL_LEFT]     <= LEFT_LIMIT_RST;
            cfg_reg.cooldown[SEL_LEFT]  <= LEFT_COOLDOWN_RST;
            cfg_reg.limit[SEL_RIGHT]    <= RIGHT_LIMIT_RST;
            cfg_reg.cooldown[SEL_RIGHT] <= RIGHT_COOLDOWN_RST;
            cfg_reg.window              <= WINDOW_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    crl_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .req_type   (s_tuser[1:0]),
        .key_value  (s_tuser[3:2]),
        .time_ms    (s_tdata),
        .item       (fr_item),
        .item_valid (fr_valid),
        .item_ready (fr_ready)
    );

    crl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_item   (fr_item),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .out_item  (q_item),
        .out_valid (q_valid),
        .out_ready (q_ready)
    );

    crl_back #(
        .RING_DEPTH (RING_DEPTH),
        .STAMP_BITS (STAMP_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item         (q_item),
        .item_valid   (q_valid),
        .item_ready   (q_ready),
        .cfg          (cfg_reg),
        .result       (res),
        .result_valid (m_tvalid),
        .result_ready (m_tready)
    );

    assign m_tdata = res.clicks;
    assign m_tuser = {res.verdict, res.forward};

endmodule

// ===== rtl/core/crl_checker.sv =====
`include "assert_macros.svh"

module crl_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [2:0] m_tuser
);
    import crl_pkg::*;

    // A stalled result must stay on the bus unchanged.
    `CRL_ASSERT_DIS(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // Only a passed event is forwarded.
    `CRL_ASSERT_DIS(a_fwd_verdict, aclk, aresetn, m_tvalid |-> (m_tuser[0] == (m_tuser[2:1] == VERDICT_PASS)), "forward flag disagrees with verdict")

    // No result may be offered right after a reset cycle.
    `CRL_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind click_rate_limiter crl_checker u_crl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
